// ===== rtl/core/tsl_pkg.sv =====
// shared types, register indexes and constants of the terrain slope block
package tsl_pkg;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_RD   = 11'b00000000010,
		ST_DIV  = 11'b00000000100,
		ST_SQX  = 11'b00000001000,
		ST_SQY  = 11'b00000010000,
		ST_ADD  = 11'b00000100000,
		ST_SQRT = 11'b00001000000,
		ST_FIN  = 11'b00010000000,
		ST_CORD = 11'b00100000000,
		ST_DEG  = 11'b01000000000,
		ST_OUT  = 11'b10000000000
	} st_t;

	localparam logic [2:0] CFG_ROW_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_ALGORITHM   = 3'd1;
	localparam logic [2:0] CFG_SLOPE_UNIT  = 3'd2;
	localparam logic [2:0] CFG_ELEV_NODATA = 3'd3;
	localparam logic [2:0] CFG_SLOPE_NODATA = 3'd4;
	localparam logic [2:0] CFG_SLOPE_LIMIT = 3'd5;
	localparam logic [2:0] CFG_CELL_X      = 3'd6;
	localparam logic [2:0] CFG_CELL_Y      = 3'd7;

	localparam int HORN_SHIFT   = 21;
	localparam int ZT_SHIFT     = 23;
	localparam int PCT_SCALE    = 100;
	localparam int CORDIC_STEPS = 17;
	localparam logic signed [24:0] DEG90 = 25'sd5898240;
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

	function automatic logic [21:0] atan_ang(input logic [4:0] i);
		logic [21:0] a;
		case (i)
			5'd0:  a = 22'd2949120;
			5'd1:  a = 22'd1740967;
			5'd2:  a = 22'd919879;
			5'd3:  a = 22'd466945;
			5'd4:  a = 22'd234379;
			5'd5:  a = 22'd117304;
			5'd6:  a = 22'd58666;
			5'd7:  a = 22'd29335;
			5'd8:  a = 22'd14668;
			5'd9:  a = 22'd7334;
			5'd10: a = 22'd3667;
			5'd11: a = 22'd1833;
			5'd12: a = 22'd917;
			5'd13: a = 22'd458;
			5'd14: a = 22'd229;
			5'd15: a = 22'd115;
			5'd16: a = 22'd57;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/terrain_slope_3x3_top.sv =====
// top level of the 3x3 terrain slope filter: line stores, window and sequencer
//
// Elevation words arrive in raster order and are taken one at a time. A word
// that completes no 3x3 window is taken in ST_IDLE, which reads the two line
// stores, and in ST_RD writes them back and shifts the window. A word that
// completes a window holds the input for the rest of its work: it goes straight
// to ST_OUT when a sample is missing or the unit gives zero, otherwise it passes
// the bit-serial dividers, the square root and, for degrees with a nonzero root,
// the 17-step cordic. A finished slope waits in the output register while the
// next word is taken.
module terrain_slope_3x3_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int ELEV_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ELEV_BITS-1:0] elevation,
	input  logic                 start_of_frame,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [23:0]          slope_value,
	output logic                 last_in_row,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int E  = ELEV_BITS;
	localparam int SW = E + 4;
	localparam int MW = E + 3;
	localparam int NW = E + 26;

	tsl_pkg::st_t st_q;

	logic [12:0] row_width_q;
	logic        algorithm_q;
	logic [1:0]  slope_unit_q;
	logic [23:0] elev_nodata_q;
	logic [23:0] slope_nodata_q;
	logic [23:0] slope_limit_q;
	logic [31:0] cell_x_q;
	logic [31:0] cell_y_q;

	logic [CW-1:0] col_q;
	logic [1:0]    rows_q;
	logic          out_valid_q;
	logic [23:0]   slope_value_q;
	logic          last_q;

	logic [E-1:0]  samp_s1;
	logic [CW-1:0] col_s1;
	logic [1:0]    rows_s1;
	logic [E-1:0]  win_q [6];
	logic [MW-1:0] mx_s2;
	logic [MW-1:0] my_s2;
	logic          last_s2;
	logic [23:0]   res_q;
	logic [61:0]   sqx_q;
	logic [61:0]   sqy_q;
	logic          div_start_q;

	logic [WW-1:0] w_eff;
	logic          in_acc;
	logic [CW-1:0] col_n;
	logic [E-1:0]  top_rd;
	logic [E-1:0]  mid_rd;
	logic [E-1:0]  nd;
	logic          any_nd;
	logic          full;
	logic          row_end;
	logic          is_last;
	logic signed [SW-1:0] va, vb, vc, vd, vf, vg, vh, vi;
	logic signed [SW-1:0] nx, ny;
	logic [MW-1:0] mx, my;
	logic [NW-1:0] numx, numy;
	logic          div_start;
	logic          div_done;
	logic          divy_done;
	logic [30:0]   qx, qy;
	logic [30:0]   mul_a;
	logic [61:0]   mul_p;
	logic          sqrt_start;
	logic          sqrt_done;
	logic [31:0]   root;
	logic          cord_start;
	logic          cord_done;
	logic [14:0]   deg;
	logic [38:0]   pct_full;
	logic [30:0]   pct;
	logic [23:0]   pct_sat;
	logic          out_free;

	function automatic logic [23:0] cap_fn(input logic [23:0] s, input logic [23:0] lim);
		return (s > lim) ? lim : s;
	endfunction

	always_comb begin
		if (row_width_q < 13'd3) begin
			w_eff = WW'(3);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(row_width_q);
		end
	end

	assign in_stall = (st_q != tsl_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign col_n    = start_of_frame ? '0 : col_q;
	assign out_free = !out_valid_q || !out_stall;

	tsl_ram #(.WIDTH(E), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (st_q == tsl_pkg::ST_RD),
		.waddr (col_s1),
		.wdata (mid_rd),
		.raddr (col_n),
		.rdata (top_rd)
	);

	tsl_ram #(.WIDTH(E), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (st_q == tsl_pkg::ST_RD),
		.waddr (col_s1),
		.wdata (samp_s1),
		.raddr (col_n),
		.rdata (mid_rd)
	);

	// window: a b c / d e f / g h i, right column from the stores and the new word
	assign nd = E'(elev_nodata_q);
	assign any_nd = (win_q[0] == nd) || (win_q[3] == nd) || (top_rd == nd) ||
		(win_q[1] == nd) || (win_q[4] == nd) || (mid_rd == nd) ||
		(win_q[2] == nd) || (win_q[5] == nd) || (samp_s1 == nd);

	assign va = SW'($signed(win_q[0]));
	assign vb = SW'($signed(win_q[3]));
	assign vc = SW'($signed(top_rd));
	assign vd = SW'($signed(win_q[1]));
	assign vf = SW'($signed(mid_rd));
	assign vg = SW'($signed(win_q[2]));
	assign vh = SW'($signed(win_q[5]));
	assign vi = SW'($signed(samp_s1));

	always_comb begin
		if (!algorithm_q) begin
			nx = (vc + (vf <<< 1) + vi) - (va + (vd <<< 1) + vg);
			ny = (vg + (vh <<< 1) + vi) - (va + (vb <<< 1) + vc);
		end else begin
			nx = vf - vd;
			ny = vh - vb;
		end
	end

	assign mx = (nx < 0) ? MW'(-nx) : MW'(nx);
	assign my = (ny < 0) ? MW'(-ny) : MW'(ny);

	assign full    = (rows_s1 == 2'd2) && (col_s1 >= CW'(2));
	assign row_end = (32'(col_s1) + 32'd1) >= 32'(w_eff);
	assign is_last = (32'(col_s1) + 32'd1) == 32'(w_eff);

	assign numx = algorithm_q ? (NW'(mx_s2) << tsl_pkg::ZT_SHIFT)
		: (NW'(mx_s2) << tsl_pkg::HORN_SHIFT);
	assign numy = algorithm_q ? (NW'(my_s2) << tsl_pkg::ZT_SHIFT)
		: (NW'(my_s2) << tsl_pkg::HORN_SHIFT);

	assign div_start = (st_q == tsl_pkg::ST_RD) && full && !any_nd && !slope_unit_q[1];

	tsl_div #(.NW(NW)) u_divx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (numx),
		.den    (cell_x_q),
		.done   (div_done),
		.quo    (qx)
	);

	tsl_div #(.NW(NW)) u_divy (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (numy),
		.den    (cell_y_q),
		.done   (divy_done),
		.quo    (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= div_start;
		end
	end

	assign mul_a = (st_q == tsl_pkg::ST_SQX) ? qx : qy;
	assign mul_p = 62'(mul_a) * 62'(mul_a);

	assign sqrt_start = (st_q == tsl_pkg::ST_ADD);

	tsl_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v      (64'(sqx_q) + 64'(sqy_q)),
		.done   (sqrt_done),
		.root   (root)
	);

	assign cord_start = (st_q == tsl_pkg::ST_FIN) && slope_unit_q[0] && (root != 32'd0);

	tsl_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.r      (root),
		.done   (cord_done),
		.deg    (deg)
	);

	assign pct_full = 39'(root) * 39'(tsl_pkg::PCT_SCALE);
	assign pct      = pct_full[38:8];
	assign pct_sat  = (|pct[30:24]) ? tsl_pkg::OUT_MAX : pct[23:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= tsl_pkg::ST_IDLE;
			col_q          <= '0;
			rows_q         <= '0;
			out_valid_q    <= 1'b0;
			row_width_q    <= 13'd1024;
			algorithm_q    <= 1'b0;
			slope_unit_q   <= 2'd0;
			elev_nodata_q  <= 24'h800000;
			slope_nodata_q <= 24'd0;
			slope_limit_q  <= tsl_pkg::OUT_MAX;
			cell_x_q       <= 32'd65536;
			cell_y_q       <= 32'd65536;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tsl_pkg::CFG_ROW_WIDTH:    row_width_q    <= cfg_data[12:0];
					tsl_pkg::CFG_ALGORITHM:    algorithm_q    <= cfg_data[0];
					tsl_pkg::CFG_SLOPE_UNIT:   slope_unit_q   <= cfg_data[1:0];
					tsl_pkg::CFG_ELEV_NODATA:  elev_nodata_q  <= cfg_data[23:0];
					tsl_pkg::CFG_SLOPE_NODATA: slope_nodata_q <= cfg_data[23:0];
					tsl_pkg::CFG_SLOPE_LIMIT:  slope_limit_q  <= cfg_data[23:0];
					tsl_pkg::CFG_CELL_X:       cell_x_q       <= cfg_data;
					tsl_pkg::CFG_CELL_Y:       cell_y_q       <= cfg_data;
				endcase
			end
			if (st_q == tsl_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				tsl_pkg::ST_IDLE: begin
					if (in_acc) begin
						st_q <= tsl_pkg::ST_RD;
					end
				end
				tsl_pkg::ST_RD: begin
					if (row_end) begin
						col_q  <= '0;
						rows_q <= (rows_s1 < 2'd2) ? rows_s1 + 2'd1 : rows_s1;
					end else begin
						col_q  <= col_s1 + 1'b1;
						rows_q <= rows_s1;
					end
					if (!full) begin
						st_q <= tsl_pkg::ST_IDLE;
					end else if (any_nd || slope_unit_q[1]) begin
						st_q <= tsl_pkg::ST_OUT;
					end else begin
						st_q <= tsl_pkg::ST_DIV;
					end
				end
				tsl_pkg::ST_DIV: begin
					if (div_done) begin
						st_q <= tsl_pkg::ST_SQX;
					end
				end
				tsl_pkg::ST_SQX:  st_q <= tsl_pkg::ST_SQY;
				tsl_pkg::ST_SQY:  st_q <= tsl_pkg::ST_ADD;
				tsl_pkg::ST_ADD:  st_q <= tsl_pkg::ST_SQRT;
				tsl_pkg::ST_SQRT: begin
					if (sqrt_done) begin
						st_q <= tsl_pkg::ST_FIN;
					end
				end
				tsl_pkg::ST_FIN: begin
					st_q <= cord_start ? tsl_pkg::ST_CORD : tsl_pkg::ST_OUT;
				end
				tsl_pkg::ST_CORD: begin
					if (cord_done) begin
						st_q <= tsl_pkg::ST_DEG;
					end
				end
				tsl_pkg::ST_DEG:  st_q <= tsl_pkg::ST_OUT;
				tsl_pkg::ST_OUT: begin
					if (out_free) begin
						st_q <= tsl_pkg::ST_IDLE;
					end
				end
				default: st_q <= tsl_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_s1 <= elevation;
			col_s1  <= col_n;
			rows_s1 <= start_of_frame ? 2'd0 : rows_q;
		end
		if (st_q == tsl_pkg::ST_RD) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= samp_s1;
			mx_s2    <= mx;
			my_s2    <= my;
			last_s2  <= is_last;
			res_q    <= any_nd ? slope_nodata_q : 24'd0;
		end
		if (st_q == tsl_pkg::ST_SQX) begin
			sqx_q <= mul_p;
		end
		if (st_q == tsl_pkg::ST_SQY) begin
			sqy_q <= mul_p;
		end
		if (st_q == tsl_pkg::ST_FIN) begin
			res_q <= slope_unit_q[0] ? 24'd0 : cap_fn(pct_sat, slope_limit_q);
		end
		if (st_q == tsl_pkg::ST_DEG) begin
			res_q <= cap_fn(24'(deg), slope_limit_q);
		end
		if (st_q == tsl_pkg::ST_OUT && out_free) begin
			slope_value_q <= res_q;
			last_q        <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign slope_value = slope_value_q;
	assign last_in_row = last_q;

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == tsl_pkg::ST_RD)
		else $error("accepted word did not enter store read");

	a_div_to_square: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == tsl_pkg::ST_DIV && div_done |=> st_q == tsl_pkg::ST_SQX)
		else $error("divider finish not followed by squaring");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		div_done == divy_done)
		else $error("gradient dividers out of step");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == tsl_pkg::ST_OUT && !out_valid |=> out_valid)
		else $error("free output register not loaded");
`endif

endmodule

// ===== rtl/core/tsl_ram.sv =====
// generic single-port-write ram with registered read
module tsl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/tsl_div.sv =====
// bit-serial restoring divider for one gradient component, capped quotient
module tsl_div #(
	parameter int NW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [31:0]   den,
	output logic          done,
	output logic [30:0]   quo
);

	logic                    busy_q;
	logic [$clog2(NW)-1:0]   cnt_q;
	logic [31:0]             rem_q;
	logic [31:0]             den_q;
	logic [NW-1:0]           num_q;
	logic [NW-1:0]           quo_q;
	logic [32:0]             trial;
	logic [32:0]             diff;
	logic                    qbit;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});
	assign done  = busy_q && (cnt_q == ($clog2(NW))'(NW - 1));
	assign quo   = (|quo_q[NW-1:31]) ? 31'h7FFFFFFF : quo_q[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= (den == 32'd0) ? 32'd1 : den;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[31:0] : trial[31:0];
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], qbit};
		end
	end

endmodule

// ===== rtl/core/tsl_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
module tsl_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] bit_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] sum;

	assign sum  = res_q + bit_q;
	assign done = (bit_q == 64'd1);
	assign root = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= 64'd1 << 62;
		end else begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			res_q <= '0;
		end else if (bit_q != 64'd0) begin
			if (v_q >= sum) begin
				v_q   <= v_q - sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ===== rtl/core/tsl_cordic.sv =====
// vectoring cordic, one micro-rotation per cycle, angle in 1/256 degree
module tsl_cordic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] r,
	output logic        done,
	output logic [14:0] deg
);

	logic                busy_q;
	logic [4:0]          cnt_q;
	logic signed [43:0]  x_q;
	logic signed [43:0]  y_q;
	logic signed [24:0]  z_q;
	logic signed [43:0]  dx;
	logic signed [43:0]  dy;
	logic signed [43:0]  yneg;
	logic signed [24:0]  ang;
	logic [22:0]         zc;
	logic [23:0]         zr;

	assign yneg = -y_q;
	assign dx   = (y_q < 0) ? -(yneg >>> cnt_q) : (y_q >>> cnt_q);
	assign dy   = x_q >>> cnt_q;
	assign ang  = 25'(tsl_pkg::atan_ang(cnt_q));
	assign done = busy_q && (cnt_q == 5'(tsl_pkg::CORDIC_STEPS - 1));

	always_comb begin
		if (z_q < 0) begin
			zc = '0;
		end else if (z_q > tsl_pkg::DEG90) begin
			zc = tsl_pkg::DEG90[22:0];
		end else begin
			zc = z_q[22:0];
		end
	end

	assign zr  = {1'b0, zc} + 24'd128;
	assign deg = zr[22:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 44'sd16777216;
			y_q <= $signed(44'(r) << 8);
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
	end

endmodule
